>>> sv/midi_track_event_parser_macros.svh
// Assertion macros shared by the checker of the track event parser.
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// Implication checked in the same cycle, outside reset.
`define MTEP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Implication checked in the next cycle, outside reset.
`define MTEP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Implication checked in the next cycle, reset included.
`define MTEP_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed: reset behaviour");

`endif

>>> sv/mtep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Types and constants shared by the parser and its checker.
// ----------------------------------------------------------------------------
package mtep_pkg;

    localparam int MTEP_CHANNELS = 16;

    typedef enum logic [3:0] {
        PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_ONLY,
        PH_SYSLEN, PH_SYSDATA, PH_METATYPE, PH_METALEN, PH_METADATA
    } phase_t;

    typedef enum logic [2:0] {
        RK_SHORT    = 3'd0,
        RK_SYSEX    = 3'd1,
        RK_TEMPO    = 3'd2,
        RK_END      = 3'd3,
        RK_DELTA    = 3'd4,
        RK_READBACK = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        MOP_NONE, MOP_READ, MOP_NOTE, MOP_REG, MOP_VOL
    } mop_t;

    localparam logic [0:0] CFG_TRANSPOSE = 1'b0;
    localparam logic [0:0] CFG_GAIN      = 1'b1;

    localparam logic [2:0] CR_INSTR  = 3'd0;
    localparam logic [2:0] CR_BANK   = 3'd1;
    localparam logic [2:0] CR_VOL    = 3'd2;
    localparam logic [2:0] CR_ADJ    = 3'd3;
    localparam logic [2:0] CR_PAN    = 3'd4;
    localparam logic [2:0] CR_REVERB = 3'd5;
    localparam logic [2:0] CR_CHORUS = 3'd6;
    localparam logic [2:0] RD_NOTE   = 3'd7;

    localparam logic [7:0] META_EOT   = 8'h2f;
    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [7:0] ST_SYSEX   = 8'hf0;
    localparam logic [7:0] ST_META    = 8'hff;
    localparam logic [31:0] TEMPO_RESET = 32'd1000000;

    localparam logic [3:0] MK_NOTE_OFF = 4'h8;
    localparam logic [3:0] MK_NOTE_ON  = 4'h9;
    localparam logic [3:0] MK_CTRL     = 4'hb;
    localparam logic [3:0] MK_PROG     = 4'hc;
    localparam logic [3:0] MK_PRESS    = 4'hd;
    localparam logic [3:0] MK_SYSTEM   = 4'hf;

    localparam logic [7:0] CC_BANK   = 8'd0;
    localparam logic [7:0] CC_LSAVE  = 8'd2;
    localparam logic [7:0] CC_LREST  = 8'd4;
    localparam logic [7:0] CC_VOL    = 8'd7;
    localparam logic [7:0] CC_PAN    = 8'd10;
    localparam logic [7:0] CC_REVERB = 8'd91;
    localparam logic [7:0] CC_CHORUS = 8'd93;

    localparam logic [1:0] LOOP_NONE = 2'd0;
    localparam logic [1:0] LOOP_SAVE = 2'd1;
    localparam logic [1:0] LOOP_REST = 2'd2;

endpackage

>>> sv/midi_track_event_parser.sv
// Result path: an accepted word is registered in s2, then in the output registers.
// Throughput: one word per cycle while the output is not held; the channel memories
// are read at acceptance and written back from s2, forwarding back-to-back accesses.
// Reset: synchronous, active low; parse state, tempo and configuration take their
// initial values and per-channel valid bits make both memories read as zero.
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses track bytes into short message, sysex, tempo, end and delta results,
// and answers channel readback requests.
module midi_track_event_parser #(
    parameter int CHANNELS = mtep_pkg::MTEP_CHANNELS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [8:0]          cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [7:0]          s_data_byte,
    input  logic                s_track_start,
    input  logic [3:0]          s_read_channel,
    input  logic [2:0]          s_read_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_result_kind,
    output logic [7:0]          m_msg_status,
    output logic [7:0]          m_msg_first,
    output logic [7:0]          m_msg_second,
    output logic [1:0]          m_loop_action,
    output logic [7:0]          m_sysex_data,
    output logic                m_sysex_last,
    output logic [31:0]         m_tempo_value,
    output logic signed [31:0]  m_next_event_tick,
    output logic [7:0]          m_readback_value
);
    import mtep_pkg::*;

    localparam int ChW = $clog2(CHANNELS);

    logic signed [7:0] transpose_reg;
    logic [8:0]        gain_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  rs_reg, rs_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] rem_reg, rem_next;
    logic [7:0]  meta_reg, meta_next;
    logic [7:0]  first_reg, first_next;
    logic [31:0] tempo_reg, tempo_next;
    logic [31:0] tick_reg, tick_next;
    logic        ended_reg, ended_next;

    logic        acc_en, en;
    logic        r_has;
    kind_t       r_kind;
    logic [7:0]  r_status, r_first, r_second, r_sysex, r_val;
    logic [1:0]  r_loop;
    logic        r_last, r_set;
    logic [2:0]  r_idx;
    mop_t        r_mop;
    logic [ChW-1:0] r_ch;
    logic        sh_go, dl_go, sl_go;
    logic [7:0]  sh_first, sh_second, sh_tp, b;
    logic [31:0] vlq, rem_dec;
    logic [16:0] prod;

    logic        s2_valid_reg, s2_has_reg, s2_last_reg, s2_set_reg;
    kind_t       s2_kind_reg;
    logic [7:0]  s2_status_reg, s2_first_reg, s2_second_reg, s2_sysex_reg, s2_val_reg;
    logic [1:0]  s2_loop_reg;
    logic [31:0] s2_tempo_reg, s2_tick_reg;
    logic [2:0]  s2_idx_reg;
    mop_t        s2_mop_reg;
    logic [ChW-1:0] s2_ch_reg;

    logic [55:0]  ctl_mem [CHANNELS];
    logic [127:0] note_mem [CHANNELS];
    logic [55:0]  ctl_q_reg, fwd_ctl_reg, ctl_row, ctl_new;
    logic [127:0] note_q_reg, fwd_note_reg, note_row, note_new;
    logic         vld_q_reg, fwd_reg;
    logic [CHANNELS-1:0] vld_reg;
    logic         wr_en;
    logic [7:0]   rb_value;

    logic         m_valid_reg, m_last_reg;
    kind_t        m_kind_reg;
    logic [7:0]   m_status_reg, m_first_reg, m_second_reg, m_sysex_reg, m_rb_reg;
    logic [1:0]   m_loop_reg;
    logic [31:0]  m_tempo_reg, m_tick_reg;

    assign cfg_ready = 1'b1;
    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign acc_en    = s_valid && en;
    assign b         = s_data_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transpose_reg <= '0;
            gain_reg      <= 9'd256;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TRANSPOSE: transpose_reg <= cfg_data[7:0];
                CFG_GAIN:      gain_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next = phase_reg;
        rs_next    = rs_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        meta_next  = meta_reg;
        first_next = first_reg;
        tempo_next = tempo_reg;
        tick_next  = tick_reg;
        ended_next = ended_reg;
        r_has = 1'b0;  r_kind = RK_SHORT;  r_status = '0;  r_first = '0;
        r_second = '0; r_sysex = '0;  r_val = '0;  r_loop = LOOP_NONE;
        r_last = 1'b0; r_set = 1'b0;  r_idx = '0;  r_mop = MOP_NONE;
        r_ch = s_read_channel[ChW-1:0];
        sh_go = 1'b0;  dl_go = 1'b0;  sl_go = 1'b0;
        sh_first = '0; sh_second = '0; sh_tp = '0;
        vlq = '0;      rem_dec = rem_reg - 32'd1;  prod = '0;
        if (acc_en) begin
            if (s_track_start) begin
                phase_next = PH_DELTA;
                acc_next   = '0;
                rem_next   = '0;
                tick_next  = '0;
                ended_next = 1'b0;
            end
            rem_dec = rem_next - 32'd1;
            if (s_req_type) begin
                r_has  = 1'b1;
                r_kind = RK_READBACK;
                r_mop  = MOP_READ;
                r_idx  = s_read_item;
                r_val  = b;
            end else if (!ended_next) begin
                unique case (phase_next)
                    PH_DELTA: dl_go = 1'b1;
                    PH_STATUS: begin
                        if (!(b[7] == 1'b0 && rs_next[7] == 1'b0)) begin
                            acc_next = '0;
                            if (b[7] ? (b == ST_SYSEX) : (rs_next == ST_SYSEX)) begin
                                phase_next = PH_SYSLEN;
                                sl_go = !b[7];
                            end else if (b[7] ? (b == ST_META) : (rs_next == ST_META)) begin
                                if (!b[7]) begin
                                    meta_next  = b;
                                    phase_next = PH_METALEN;
                                end else begin
                                    phase_next = PH_METATYPE;
                                end
                            end else begin
                                if (b[7]) rs_next = b;
                                if (rs_next[7:4] == MK_SYSTEM) begin
                                    phase_next = PH_DELTA;
                                    dl_go = !b[7];
                                end else if (rs_next[7:4] == MK_PROG ||
                                             rs_next[7:4] == MK_PRESS) begin
                                    if (!b[7]) begin
                                        sh_go = 1'b1;
                                        sh_first = b;
                                    end else begin
                                        phase_next = PH_ONLY;
                                    end
                                end else if (!b[7]) begin
                                    first_next = b;
                                    phase_next = PH_DATA2;
                                end else begin
                                    phase_next = PH_DATA1;
                                end
                            end
                        end
                    end
                    PH_DATA1: begin
                        first_next = b;
                        phase_next = PH_DATA2;
                    end
                    PH_DATA2: begin
                        sh_go = 1'b1;
                        sh_first = first_reg;
                        sh_second = b;
                    end
                    PH_ONLY: begin
                        sh_go = 1'b1;
                        sh_first = b;
                    end
                    PH_SYSLEN: sl_go = 1'b1;
                    PH_SYSDATA: begin
                        rem_next = rem_dec;
                        r_has = 1'b1;
                        r_kind = RK_SYSEX;
                        r_sysex = b;
                        if (rem_dec == '0) begin
                            r_last = 1'b1;
                            rs_next = ST_SYSEX;
                            phase_next = PH_DELTA;
                            acc_next = '0;
                        end
                    end
                    PH_METATYPE: begin
                        meta_next = b;
                        acc_next = '0;
                        phase_next = PH_METALEN;
                    end
                    PH_METALEN: begin
                        vlq = {acc_next[24:0], b[6:0]};
                        if (b[7]) begin
                            acc_next = vlq;
                        end else begin
                            rem_next = vlq;
                            acc_next = '0;
                            if (meta_reg == META_EOT) begin
                                ended_next = 1'b1;
                                phase_next = PH_DELTA;
                                r_has = 1'b1;
                                r_kind = RK_END;
                            end else begin
                                if (meta_reg == META_TEMPO) tempo_next = '0;
                                if (vlq == '0) begin
                                    rs_next = ST_META;
                                    phase_next = PH_DELTA;
                                    if (meta_reg == META_TEMPO) begin
                                        r_has = 1'b1;
                                        r_kind = RK_TEMPO;
                                    end
                                end else begin
                                    phase_next = PH_METADATA;
                                end
                            end
                        end
                    end
                    PH_METADATA: begin
                        rem_next = rem_dec;
                        if (meta_reg == META_TEMPO)
                            tempo_next = {tempo_reg[23:0], 8'd0} + tempo_reg + {24'd0, b};
                        if (rem_dec == '0) begin
                            rs_next = ST_META;
                            phase_next = PH_DELTA;
                            acc_next = '0;
                            if (meta_reg == META_TEMPO) begin
                                r_has = 1'b1;
                                r_kind = RK_TEMPO;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_DELTA;
                        acc_next = '0;
                    end
                endcase
                vlq = {acc_next[24:0], b[6:0]};
                if (dl_go) begin
                    if (b[7]) begin
                        acc_next = vlq;
                    end else begin
                        tick_next = tick_next + vlq;
                        acc_next = '0;
                        phase_next = PH_STATUS;
                        r_has = 1'b1;
                        r_kind = RK_DELTA;
                    end
                end
                if (sl_go) begin
                    if (b[7]) begin
                        acc_next = vlq;
                    end else begin
                        rem_next = vlq;
                        acc_next = '0;
                        r_has = 1'b1;
                        r_kind = RK_SYSEX;
                        r_sysex = ST_SYSEX;
                        if (vlq == '0) begin
                            r_last = 1'b1;
                            rs_next = ST_SYSEX;
                            phase_next = PH_DELTA;
                        end else begin
                            phase_next = PH_SYSDATA;
                        end
                    end
                end
                if (sh_go) begin
                    r_has = 1'b1;
                    r_kind = RK_SHORT;
                    r_status = rs_next;
                    r_ch = rs_next[ChW-1:0];
                    r_first = sh_first;
                    r_second = sh_second;
                    phase_next = PH_DELTA;
                    acc_next = '0;
                    sh_tp = sh_first + transpose_reg;
                    prod = sh_second * gain_reg;
                    case (rs_next[7:4])
                        MK_NOTE_OFF, MK_NOTE_ON: begin
                            r_first = sh_tp;
                            r_idx = sh_tp[6:0] > 7'd0 ? 3'd0 : 3'd0;
                            if (!sh_tp[7]) r_mop = MOP_NOTE;
                            r_set = (rs_next[7:4] == MK_NOTE_ON) && (sh_second != '0);
                            r_val = sh_tp;
                        end
                        MK_PROG: begin
                            r_mop = MOP_REG;
                            r_idx = CR_INSTR;
                            r_val = sh_first;
                        end
                        MK_CTRL: begin
                            r_val = sh_second;
                            case (sh_first)
                                CC_BANK:   begin r_mop = MOP_REG; r_idx = CR_BANK; end
                                CC_LSAVE:  r_loop = LOOP_SAVE;
                                CC_LREST:  r_loop = LOOP_REST;
                                CC_VOL: begin
                                    r_mop = MOP_VOL;
                                    r_second = (prod[16:8] > 9'd127) ? 8'd127 : prod[15:8];
                                end
                                CC_PAN:    begin r_mop = MOP_REG; r_idx = CR_PAN; end
                                CC_REVERB: begin r_mop = MOP_REG; r_idx = CR_REVERB; end
                                CC_CHORUS: begin r_mop = MOP_REG; r_idx = CR_CHORUS; end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DELTA;
            rs_reg    <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            meta_reg  <= '0;
            first_reg <= '0;
            tempo_reg <= TEMPO_RESET;
            tick_reg  <= '0;
            ended_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            rs_reg    <= rs_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            meta_reg  <= meta_next;
            first_reg <= first_next;
            tempo_reg <= tempo_next;
            tick_reg  <= tick_next;
            ended_reg <= ended_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= acc_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_has_reg    <= r_has;
            s2_kind_reg   <= r_kind;
            s2_status_reg <= r_status;
            s2_first_reg  <= r_first;
            s2_second_reg <= r_second;
            s2_sysex_reg  <= r_sysex;
            s2_last_reg   <= r_last;
            s2_loop_reg   <= r_loop;
            s2_tempo_reg  <= (r_kind == RK_TEMPO) ? tempo_next : '0;
            s2_tick_reg   <= (r_kind == RK_DELTA) ? tick_next : '0;
            s2_mop_reg    <= r_has ? r_mop : MOP_NONE;
            s2_idx_reg    <= r_idx;
            s2_val_reg    <= r_val;
            s2_set_reg    <= r_set;
            s2_ch_reg     <= r_ch;
        end
    end

    assign ctl_row  = fwd_reg ? fwd_ctl_reg : (vld_q_reg ? ctl_q_reg : '0);
    assign note_row = fwd_reg ? fwd_note_reg : (vld_q_reg ? note_q_reg : '0);
    assign wr_en    = en && s2_valid_reg &&
                      (s2_mop_reg == MOP_NOTE || s2_mop_reg == MOP_REG ||
                       s2_mop_reg == MOP_VOL);

    always_comb begin
        ctl_new  = ctl_row;
        note_new = note_row;
        rb_value = '0;
        case (s2_mop_reg)
            MOP_NOTE: note_new[s2_val_reg[6:0]] = s2_set_reg;
            MOP_REG:  ctl_new[8*s2_idx_reg +: 8] = s2_val_reg;
            MOP_VOL: begin
                ctl_new[8*CR_VOL +: 8] = s2_val_reg;
                ctl_new[8*CR_ADJ +: 8] = s2_second_reg;
            end
            MOP_READ: begin
                if (s2_idx_reg == RD_NOTE)
                    rb_value = {7'd0, !s2_val_reg[7] && note_row[s2_val_reg[6:0]]};
                else
                    rb_value = ctl_row[8*s2_idx_reg +: 8];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ctl_mem[s2_ch_reg]  <= ctl_new;
            note_mem[s2_ch_reg] <= note_new;
        end
        if (acc_en) begin
            ctl_q_reg    <= ctl_mem[r_ch];
            note_q_reg   <= note_mem[r_ch];
            vld_q_reg    <= vld_reg[r_ch];
            fwd_reg      <= wr_en && (s2_ch_reg == r_ch);
            fwd_ctl_reg  <= ctl_new;
            fwd_note_reg <= note_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[s2_ch_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= s2_valid_reg && s2_has_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_kind_reg   <= s2_kind_reg;
            m_status_reg <= s2_status_reg;
            m_first_reg  <= s2_first_reg;
            m_second_reg <= s2_second_reg;
            m_loop_reg   <= s2_loop_reg;
            m_sysex_reg  <= s2_sysex_reg;
            m_last_reg   <= s2_last_reg;
            m_tempo_reg  <= s2_tempo_reg;
            m_tick_reg   <= s2_tick_reg;
            m_rb_reg     <= rb_value;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_result_kind     = m_kind_reg;
    assign m_msg_status      = m_status_reg;
    assign m_msg_first       = m_first_reg;
    assign m_msg_second      = m_second_reg;
    assign m_loop_action     = m_loop_reg;
    assign m_sysex_data      = m_sysex_reg;
    assign m_sysex_last      = m_last_reg;
    assign m_tempo_value     = m_tempo_reg;
    assign m_next_event_tick = m_tick_reg;
    assign m_readback_value  = m_rb_reg;

endmodule

>>> sv/mtep_checker.sv
// ----------------------------------------------------------------------------
// MIDI track event parser checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "midi_track_event_parser_macros.svh"

module mtep_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_result_kind,
    input logic [7:0] m_msg_status,
    input logic [7:0] m_msg_first,
    input logic [7:0] m_msg_second,
    input logic [1:0] m_loop_action
);
    import mtep_pkg::*;

    `MTEP_ASSERT_RST(a_reset_empty, !aresetn, !m_valid)
    `MTEP_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_result_kind))
    `MTEP_ASSERT_IMPL(a_loop_short, m_valid && m_loop_action != LOOP_NONE, m_result_kind == RK_SHORT)
    `MTEP_ASSERT_IMPL(a_vol_clamp, m_valid && m_result_kind == RK_SHORT && m_msg_status[7:4] == MK_CTRL && m_msg_first == CC_VOL, m_msg_second <= 8'd127)

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_kind (m_result_kind),
    .m_msg_status  (m_msg_status),
    .m_msg_first   (m_msg_first),
    .m_msg_second  (m_msg_second),
    .m_loop_action (m_loop_action)
);
